FILE: hdl/gpmf_pkg.sv
// Package for the gated pitch median filter: codes, constants and shared types.
// No dependencies; used by every module under hdl.
package gpmf_pkg;

    localparam int WINDOW_DEF = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int PITCH_W = 16;
    localparam int BUCKET_W = 2;
    localparam int THIRD_NUM = 1290;
    localparam int THIRD_SHIFT = 10;   // denominator 1024

    localparam logic [BUCKET_W-1:0] BUCKET_NONE = 2'd0;
    localparam logic [BUCKET_W-1:0] BUCKET_LOW = 2'd1;
    localparam logic [BUCKET_W-1:0] BUCKET_IN_RANGE = 2'd2;
    localparam logic [BUCKET_W-1:0] BUCKET_HIGH = 2'd3;

    typedef struct packed {
        logic [PITCH_W-1:0]  pitch;
        logic [BUCKET_W-1:0] bucket;
        logic                onset;
    } gpmf_item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        gpmf_item_t item;
    } gpmf_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MED,
        ST_EMIT
    } gpmf_state_t;

endpackage

FILE: hdl/gpmf_front.sv
// Front end: stream input port and a two-entry item queue.
// Depends on gpmf_pkg.
module gpmf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,
    input  logic                pop,
    output gpmf_pkg::gpmf_head_t head
);
    import gpmf_pkg::*;

    gpmf_item_t q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    gpmf_item_t in_item;

    assign in_item.pitch  = s_axis_tdata[15:0];
    assign in_item.bucket = s_axis_tdata[17:16];
    assign in_item.onset  = s_axis_tdata[18];

    assign s_axis_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head.valid    = (count_reg != 2'd0);
    assign head.item     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hdl/gpmf_back.sv
// Back end: window, lock tracking, majority and median search, output register.
// Depends on gpmf_pkg.
module gpmf_back
#(
    parameter int WINDOW = gpmf_pkg::WINDOW_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gpmf_pkg::gpmf_head_t head,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata
);
    import gpmf_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    gpmf_state_t state_reg, state_next;

    logic [PITCH_W-1:0]  win_pitch_reg  [WINDOW];
    logic [BUCKET_W-1:0] win_bucket_reg [WINDOW];
    logic [BUCKET_W-1:0] last_bucket_reg;
    logic                lock_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [PITCH_W-1:0]  lo_reg, hi_reg, med_reg;
    logic                same_reg;
    logic [CNT_W-1:0]    cnt_reg [4];
    logic [BUCKET_W-1:0] maj_reg;

    logic                out_valid_reg;
    logic [PITCH_W-1:0]  out_pitch_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic                out_locked_reg, out_cv_reg;

    logic                out_free, scan_done;
    logic [PITCH_W-1:0]  cur_pitch;
    logic [BUCKET_W-1:0] cur_bucket;
    logic [CNT_W-1:0]    less_cnt, eq_cnt, half;
    logic [26:0]         lo_scaled, hi_scaled;
    logic                third_ok, lock_new;
    logic [BUCKET_W-1:0] maj_new;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign scan_done  = (idx_reg == LAST_IDX);
    assign cur_pitch  = win_pitch_reg[idx_reg];
    assign cur_bucket = win_bucket_reg[idx_reg];
    assign half       = cnt_reg[2] >> 1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (head.valid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = (lock_new && maj_new == BUCKET_IN_RANGE) ? ST_MED : ST_EMIT;
            ST_MED:    if (scan_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop = (state_reg == ST_IDLE) && head.valid;
    end

    // lock test and majority vote
    always_comb
    begin
        lo_scaled = 27'(lo_reg) * 27'(THIRD_NUM);
        hi_scaled = 27'(hi_reg) << THIRD_SHIFT;
        third_ok  = hi_scaled < lo_scaled;
        lock_new  = lock_reg || (same_reg && last_bucket_reg != BUCKET_IN_RANGE) || third_ok;
        maj_new   = BUCKET_NONE;
        if (cnt_reg[BUCKET_LOW] > cnt_reg[maj_new]) maj_new = BUCKET_LOW;
        if (cnt_reg[BUCKET_IN_RANGE] > cnt_reg[maj_new]) maj_new = BUCKET_IN_RANGE;
        if (cnt_reg[BUCKET_HIGH] > cnt_reg[maj_new]) maj_new = BUCKET_HIGH;
    end

    // rank of the current candidate among in-range entries
    always_comb
    begin
        less_cnt = '0;
        eq_cnt   = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (win_bucket_reg[j] == BUCKET_IN_RANGE)
            begin
                less_cnt = less_cnt + CNT_W'(win_pitch_reg[j] < cur_pitch);
                eq_cnt   = eq_cnt + CNT_W'(win_pitch_reg[j] == cur_pitch);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_bucket_reg <= BUCKET_NONE;
            lock_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_pitch_reg[i]  <= '0;
                win_bucket_reg[i] <= BUCKET_NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        for (int i = 0; i < WINDOW - 1; i++)
                        begin
                            win_pitch_reg[i]  <= win_pitch_reg[i+1];
                            win_bucket_reg[i] <= win_bucket_reg[i+1];
                        end
                        win_pitch_reg[WINDOW-1]  <= head.item.pitch;
                        win_bucket_reg[WINDOW-1] <= head.item.bucket;
                        if (head.item.onset) lock_reg <= 1'b0;
                        if (head.item.bucket != BUCKET_NONE)
                        begin
                            last_bucket_reg <= head.item.bucket;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    lock_reg <= lock_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_reg <= '0;
                med_reg <= '0;
            end
            ST_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    lo_reg   <= cur_pitch;
                    hi_reg   <= cur_pitch;
                    same_reg <= (last_bucket_reg != BUCKET_NONE) && (cur_bucket == last_bucket_reg);
                    for (int k = 0; k < 4; k++)
                    begin
                        cnt_reg[k] <= CNT_W'(cur_bucket == BUCKET_W'(k));
                    end
                end
                else
                begin
                    if (cur_pitch < lo_reg) lo_reg <= cur_pitch;
                    if (cur_pitch > hi_reg) hi_reg <= cur_pitch;
                    same_reg <= same_reg && (cur_bucket == last_bucket_reg);
                    for (int k = 0; k < 4; k++)
                    begin
                        cnt_reg[k] <= cnt_reg[k] + CNT_W'(cur_bucket == BUCKET_W'(k));
                    end
                end
                idx_reg <= scan_done ? '0 : idx_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                maj_reg <= maj_new;
            end
            ST_MED:
            begin
                if (cur_bucket == BUCKET_IN_RANGE && less_cnt <= half
                    && half < less_cnt + eq_cnt)
                begin
                    med_reg <= cur_pitch;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_locked_reg <= lock_reg;
                    out_bucket_reg <= lock_reg ? maj_reg : BUCKET_NONE;
                    out_cv_reg     <= lock_reg && maj_reg == BUCKET_IN_RANGE;
                    out_pitch_reg  <= (lock_reg && maj_reg == BUCKET_IN_RANGE) ? med_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_cv_reg, out_locked_reg, out_bucket_reg, out_pitch_reg};

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_SCAN)
        else $error("pop outside idle");
    a_cv_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cv_reg |-> out_locked_reg && out_bucket_reg == BUCKET_IN_RANGE)
        else $error("constraint without lock");
    a_unlocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_locked_reg |-> out_bucket_reg == BUCKET_NONE && out_pitch_reg == '0)
        else $error("unlocked result not empty");
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not loaded");

endmodule

FILE: hdl/gated_pitch_median_filter.sv
// Gated pitch median filter, top level: front queue plus back-end sequencer.
// The back end steps through the window one entry a cycle for the scan, and again
// for the median rank search when that runs; it takes the next item from the queue
// only once the result of the last one is loaded into the output register. The front
// queue holds two items. Reset (rst_n low, asynchronous) empties queue and window,
// clears lock.
module gated_pitch_median_filter
#(
    parameter int WINDOW = gpmf_pkg::WINDOW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // raw_pitch[15:0], raw_bucket[17:16], onset[18], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // filtered_pitch[15:0], filtered_bucket[17:16],
                                        // locked[18], constraint_valid[19], zero
);
    import gpmf_pkg::*;

    gpmf_head_t head;
    logic       pop;

    // front end: takes items while the queue has room
    gpmf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (pop),
        .head          (head)
    );

    // back end: window update, lock, majority and median, output register
    gpmf_back #(.WINDOW(WINDOW)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
